>>> sv/lswc_pkg.sv
package lswc_pkg;

  // Region code bits of an endpoint against the window.
  localparam logic [3:0] CODE_LEFT  = 4'h1;
  localparam logic [3:0] CODE_RIGHT = 4'h2;
  localparam logic [3:0] CODE_BELOW = 4'h4;
  localparam logic [3:0] CODE_ABOVE = 4'h8;

  typedef enum logic [1:0] {
    CFG_XMIN = 2'd0,
    CFG_XMAX = 2'd1,
    CFG_YMIN = 2'd2,
    CFG_YMAX = 2'd3
  } cfg_idx_t;

endpackage

>>> sv/lswc_seg_if.sv
interface lswc_seg_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> sv/lswc_clip_if.sv
interface lswc_clip_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [W-1:0] out_x0;
  logic signed [W-1:0] out_y0;
  logic signed [W-1:0] out_x1;
  logic signed [W-1:0] out_y1;

  modport source(output valid, visible, out_x0, out_y0, out_x1, out_y1, input ready);
  modport sink(input valid, visible, out_x0, out_y0, out_x1, out_y1, output ready);
endinterface

>>> sv/lswc_muldiv.sv
module lswc_muldiv import lswc_pkg::*; #(
  parameter int MB = 17,
  parameter int SB = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [SB-1:0]        in_sb,
  input  logic signed [MB-1:0] p,
  input  logic signed [MB-1:0] d,
  input  logic signed [MB-1:0] q,
  output logic                 out_valid,
  output logic [SB-1:0]        out_sb,
  output logic signed [MB-1:0] quo
);

  // trunc(p * d / q) for |p| < |q|: one multiply stage, then one quotient
  // bit per stage. The remainder starts at the high half of the product,
  // which is below the divisor, so MB quotient bits suffice.
  logic          v  [0:MB];
  logic [MB-1:0] rm [0:MB];
  logic [MB-1:0] lo [0:MB];
  logic [MB-1:0] dv [0:MB];
  logic          ng [0:MB];
  logic [SB-1:0] sb [0:MB];

  logic [MB-1:0]   ma, mb, mq;
  logic [2*MB-1:0] prod;

  assign ma   = p[MB-1] ? MB'(-p) : MB'(p);
  assign mb   = d[MB-1] ? MB'(-d) : MB'(d);
  assign mq   = q[MB-1] ? MB'(-q) : MB'(q);
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rm[0] <= prod[2*MB-1:MB];
      lo[0] <= prod[MB-1:0];
      dv[0] <= mq;
      ng[0] <= p[MB-1] ^ d[MB-1] ^ q[MB-1];
      sb[0] <= in_sb;
    end
  end

  for (genvar i = 1; i <= MB; i++) begin : g_step
    logic [MB:0] r2, diff;
    logic        ge;
    assign r2   = {rm[i-1], lo[i-1][MB-1]};
    assign diff = r2 - {1'b0, dv[i-1]};
    assign ge   = r2 >= {1'b0, dv[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
      if (en) begin
        rm[i] <= ge ? diff[MB-1:0] : r2[MB-1:0];
        lo[i] <= {lo[i-1][MB-2:0], ge};
        dv[i] <= dv[i-1];
        ng[i] <= ng[i-1];
        sb[i] <= sb[i-1];
      end
    end
  end

  assign out_valid = v[MB];
  assign out_sb    = sb[MB];
  assign quo       = ng[MB] ? -$signed(lo[MB]) : $signed(lo[MB]);

endmodule

>>> sv/line_segment_window_clip_top.sv
// Channel   Dir  Beat
// seg       in   start_x, start_y, end_x, end_y
// clip      out  visible, out_x0, out_y0, out_x1, out_y1
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One segment enters per cycle while clip is not stalled. The pipeline is
// four chained multiply-divide units, each a multiply stage plus one
// quotient bit per stage, with one register stage around each unit.
// Reset clears all valid bits and loads the window reset values.
// A stall on clip freezes the whole pipeline; seg.ready falls with it.
module line_segment_window_clip_top import lswc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  lswc_seg_if.sink              seg,
  lswc_clip_if.source           clip
);

  localparam int W  = COORD_BITS;
  localparam int MB = W + 1;
  localparam int SB = 4 * W + 3;

  typedef logic signed [W-1:0]  crd_t;
  typedef logic signed [MB-1:0] dif_t;

  function automatic logic [3:0] region(crd_t x, crd_t y, crd_t xl, crd_t xh,
                                        crd_t yl, crd_t yh);
    logic [3:0] c;
    c = '0;
    if (x < xl) c = c | CODE_LEFT;
    if (x > xh) c = c | CODE_RIGHT;
    if (y < yl) c = c | CODE_BELOW;
    if (y > yh) c = c | CODE_ABOVE;
    return c;
  endfunction

  function automatic dif_t ext(crd_t v);
    return {v[W-1], v};
  endfunction

  // Configuration and the ordered window.
  crd_t xmin, xmax, ymin, ymax;
  crd_t xl, xh, yl, yh;

  always_ff @(posedge clk) begin
    if (rst) begin
      xmin <= '0;
      xmax <= W'(1023);
      ymin <= '0;
      ymax <= W'(767);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_XMIN: xmin <= cfg_data;
        CFG_XMAX: xmax <= cfg_data;
        CFG_YMIN: ymin <= cfg_data;
        CFG_YMAX: ymax <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_comb begin
    xl = (xmin > xmax) ? xmax : xmin;
    xh = (xmin > xmax) ? xmin : xmax;
    yl = (ymin > ymax) ? ymax : ymin;
    yh = (ymin > ymax) ? ymin : ymax;
  end

  logic en;
  assign en        = !clip.valid || clip.ready;
  assign seg.ready = en;

  // Stage A: order endpoints by x, trivial reject, left-clip test.
  logic a_v, a_ok, a_need;
  crd_t a_ax, a_ay, a_bx, a_by;
  logic sw;
  crd_t n_ax, n_ay, n_bx, n_by;

  always_comb begin
    sw   = seg.start_x > seg.end_x;
    n_ax = sw ? seg.end_x : seg.start_x;
    n_ay = sw ? seg.end_y : seg.start_y;
    n_bx = sw ? seg.start_x : seg.end_x;
    n_by = sw ? seg.start_y : seg.end_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= seg.valid;
    end
    if (en) begin
      a_ok   <= (region(n_ax, n_ay, xl, xh, yl, yh) &
                 region(n_bx, n_by, xl, xh, yl, yh)) == '0;
      a_need <= n_ax < xl;
      a_ax   <= n_ax;
      a_ay   <= n_ay;
      a_bx   <= n_bx;
      a_by   <= n_by;
    end
  end

  logic          d1_v, d2_v, d3_v, d4_v;
  logic [SB-1:0] d1_sb, d2_sb, d3_sb, d4_sb;
  dif_t          d1_q, d2_q, d3_q, d4_q;

  lswc_muldiv #(.MB(MB), .SB(SB)) u_div1 (
    .clk, .rst, .en, .in_valid(a_v),
    .in_sb({a_ok, a_need, 1'b0, a_ax, a_ay, a_bx, a_by}),
    .p(ext(a_bx) - ext(xl)), .d(ext(a_by) - ext(a_ay)), .q(ext(a_bx) - ext(a_ax)),
    .out_valid(d1_v), .out_sb(d1_sb), .quo(d1_q)
  );

  // Stage B: apply left clip, recheck codes, vertical test for first end.
  logic b_v, b_ok, b_need, b_sel;
  crd_t b_ax, b_ay, b_bx, b_by;
  logic u1_ok, u1_need;
  crd_t u1_ax, u1_ay, u1_bx, u1_by, bn_ax, bn_ay;
  dif_t t1;

  always_comb begin
    {u1_ok, u1_need} = d1_sb[SB-1:SB-2];
    {u1_ax, u1_ay, u1_bx, u1_by} = d1_sb[4*W-1:0];
    t1    = ext(u1_by) - d1_q;
    bn_ax = (u1_ok && u1_need) ? xl : u1_ax;
    bn_ay = (u1_ok && u1_need) ? t1[W-1:0] : u1_ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= d1_v;
    end
    if (en) begin
      b_ok   <= u1_ok && ((region(bn_ax, bn_ay, xl, xh, yl, yh) &
                           region(u1_bx, u1_by, xl, xh, yl, yh)) == '0);
      b_need <= (bn_ay < yl) || (bn_ay > yh);
      b_sel  <= bn_ay > yh;
      b_ax   <= bn_ax;
      b_ay   <= bn_ay;
      b_bx   <= u1_bx;
      b_by   <= u1_by;
    end
  end

  lswc_muldiv #(.MB(MB), .SB(SB)) u_div2 (
    .clk, .rst, .en, .in_valid(b_v),
    .in_sb({b_ok, b_need, b_sel, b_ax, b_ay, b_bx, b_by}),
    .p(ext(b_by) - ext(b_sel ? yh : yl)), .d(ext(b_bx) - ext(b_ax)),
    .q(ext(b_by) - ext(b_ay)),
    .out_valid(d2_v), .out_sb(d2_sb), .quo(d2_q)
  );

  // Stage C: apply vertical clip of first end, right reject, test second end.
  logic c_v, c_ok, c_need, c_sel;
  crd_t c_ax, c_ay, c_bx, c_by;
  logic u2_ok, u2_need, u2_sel;
  crd_t u2_ax, u2_ay, u2_bx, u2_by, cn_ax, cn_ay;
  dif_t t2;

  always_comb begin
    {u2_ok, u2_need, u2_sel} = d2_sb[SB-1:SB-3];
    {u2_ax, u2_ay, u2_bx, u2_by} = d2_sb[4*W-1:0];
    t2    = ext(u2_bx) - d2_q;
    cn_ax = (u2_ok && u2_need) ? t2[W-1:0] : u2_ax;
    cn_ay = (u2_ok && u2_need) ? (u2_sel ? yh : yl) : u2_ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= d2_v;
    end
    if (en) begin
      c_ok   <= u2_ok && !(cn_ax > xh);
      c_need <= (u2_by > yh) || (u2_by < yl);
      c_sel  <= u2_by > yh;
      c_ax   <= cn_ax;
      c_ay   <= cn_ay;
      c_bx   <= u2_bx;
      c_by   <= u2_by;
    end
  end

  lswc_muldiv #(.MB(MB), .SB(SB)) u_div3 (
    .clk, .rst, .en, .in_valid(c_v),
    .in_sb({c_ok, c_need, c_sel, c_ax, c_ay, c_bx, c_by}),
    .p(ext(c_sel ? yh : yl) - ext(c_ay)), .d(ext(c_bx) - ext(c_ax)),
    .q(ext(c_by) - ext(c_ay)),
    .out_valid(d3_v), .out_sb(d3_sb), .quo(d3_q)
  );

  // Stage D: apply vertical clip of second end, right-clip test.
  logic e_v, e_ok, e_need;
  crd_t e_ax, e_ay, e_bx, e_by;
  logic u3_ok, u3_need, u3_sel;
  crd_t u3_ax, u3_ay, u3_bx, u3_by, dn_bx, dn_by;
  dif_t t3;

  always_comb begin
    {u3_ok, u3_need, u3_sel} = d3_sb[SB-1:SB-3];
    {u3_ax, u3_ay, u3_bx, u3_by} = d3_sb[4*W-1:0];
    t3    = ext(u3_ax) + d3_q;
    dn_bx = (u3_ok && u3_need) ? t3[W-1:0] : u3_bx;
    dn_by = (u3_ok && u3_need) ? (u3_sel ? yh : yl) : u3_by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d3_v;
    end
    if (en) begin
      e_ok   <= u3_ok;
      e_need <= dn_bx > xh;
      e_ax   <= u3_ax;
      e_ay   <= u3_ay;
      e_bx   <= dn_bx;
      e_by   <= dn_by;
    end
  end

  lswc_muldiv #(.MB(MB), .SB(SB)) u_div4 (
    .clk, .rst, .en, .in_valid(e_v),
    .in_sb({e_ok, e_need, 1'b0, e_ax, e_ay, e_bx, e_by}),
    .p(ext(xh) - ext(e_ax)), .d(ext(e_by) - ext(e_ay)), .q(ext(e_bx) - ext(e_ax)),
    .out_valid(d4_v), .out_sb(d4_sb), .quo(d4_q)
  );

  // Output stage: apply right clip of second end.
  logic u4_ok, u4_need;
  crd_t u4_ax, u4_ay, u4_bx, u4_by;
  dif_t t4;

  always_comb begin
    {u4_ok, u4_need} = d4_sb[SB-1:SB-2];
    {u4_ax, u4_ay, u4_bx, u4_by} = d4_sb[4*W-1:0];
    t4 = ext(u4_ay) + d4_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.valid <= 1'b0;
    end else if (en) begin
      clip.valid <= d4_v;
    end
    if (en) begin
      clip.visible <= u4_ok;
      clip.out_x0  <= u4_ok ? u4_ax : '0;
      clip.out_y0  <= u4_ok ? u4_ay : '0;
      clip.out_x1  <= !u4_ok ? '0 : (u4_need ? xh : u4_bx);
      clip.out_y1  <= !u4_ok ? '0 : (u4_need ? t4[W-1:0] : u4_by);
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    clip.valid && !clip.visible |->
      clip.out_x0 == '0 && clip.out_y0 == '0 && clip.out_x1 == '0 && clip.out_y1 == '0)
    else $error("rejected segment carries nonzero coordinates");

  a_x_order: assert property (@(posedge clk) disable iff (rst)
    clip.valid && clip.visible |-> clip.out_x0 <= clip.out_x1)
    else $error("visible segment has endpoints out of x order");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !clip.valid)
    else $error("result valid right after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    clip.valid && !clip.ready |-> !seg.ready)
    else $error("input taken while pipeline is stalled");

endmodule
